// ===== hw/rtl/spq_pkg.sv =====
// Shared types for the stable priority queue.
`timescale 1ns / 1ps
package spq_pkg;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } spq_status_t;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } spq_op_t;

  // Per-cycle command broadcast to every cell.
  typedef struct packed {
    logic push;
    logic pop;
  } spq_ctl_t;

endpackage

// ===== hw/rtl/spq_cell.sv =====
// One slot of the sorted shift-register queue.
`timescale 1ns / 1ps
module spq_cell import spq_pkg::*; #(
  parameter int PAYLOAD_BITS = 32,
  parameter int RANK_BITS    = 8
) (
  input  logic                    clk,
  input  spq_ctl_t                ctl,
  input  logic [RANK_BITS-1:0]    new_rank,
  input  logic [PAYLOAD_BITS-1:0] new_payload,
  input  logic                    occupied,
  input  logic                    left_keep,
  input  logic [RANK_BITS-1:0]    left_rank,
  input  logic [PAYLOAD_BITS-1:0] left_payload,
  input  logic [RANK_BITS-1:0]    right_rank,
  input  logic [PAYLOAD_BITS-1:0] right_payload,
  output logic                    keep,
  output logic [RANK_BITS-1:0]    slot_rank,
  output logic [PAYLOAD_BITS-1:0] slot_payload
);

  logic [RANK_BITS-1:0]    slot_rank_next;
  logic [PAYLOAD_BITS-1:0] slot_payload_next;

  // An occupied slot that ranks at or above the newcomer stays put (ties keep order).
  assign keep = occupied && (slot_rank >= new_rank);

  always_comb begin
    slot_rank_next    = slot_rank;
    slot_payload_next = slot_payload;
    if (ctl.push && !keep) begin
      if (left_keep) begin
        slot_rank_next    = new_rank;
        slot_payload_next = new_payload;
      end else begin
        slot_rank_next    = left_rank;
        slot_payload_next = left_payload;
      end
    end else if (ctl.pop) begin
      slot_rank_next    = right_rank;
      slot_payload_next = right_payload;
    end
  end

  always_ff @(posedge clk) begin
    slot_rank    <= slot_rank_next;
    slot_payload <= slot_payload_next;
  end

endmodule

// ===== hw/rtl/stable_priority_queue.sv =====
// Top level of the stable priority queue: cell row, fill count and result register.
//
// Input channel (in_valid/in_stall): operation 0 pushes {payload, rank}, 1 pops the head.
// Output channel (out_valid/out_stall): one result transaction per input transaction,
// carrying status, the popped entry, the occupancy and the head entry after the operation.
// Entries sit in a row of CAPACITY cells kept sorted by rank, highest at cell 0; equal
// ranks stay in arrival order. A push makes every cell compare against the new rank in
// parallel and the row opens a gap by shifting one place; a pop shifts the row down one.
// The result is registered and appears in the cycle after the input transaction is accepted.
// Throughput: one transaction per cycle while no pending result is stalled; the whole row updates at once.
// The output register parts the two sides: a new input is taken whenever the result
// register is empty or its content is taken in the same cycle. While out_stall holds a
// pending result, in_stall is high and the queue holds its contents.
// A push into a full queue leaves it unchanged with status full; a pop from an empty
// queue leaves it unchanged with status empty; popped fields are zero in both cases.
// Reset (rst, synchronous) empties the queue and drops any pending result; cell
// contents are not cleared, only the fill count.
`timescale 1ns / 1ps
module stable_priority_queue import spq_pkg::*; #(
  parameter int CAPACITY     = 16,
  parameter int PAYLOAD_BITS = 32,
  parameter int RANK_BITS    = 8,
  localparam int CNT_W       = $clog2(CAPACITY + 1)
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    operation,
  input  logic [PAYLOAD_BITS-1:0] payload,
  input  logic [RANK_BITS-1:0]    rank,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [1:0]              status,
  output logic [PAYLOAD_BITS-1:0] popped_payload,
  output logic [RANK_BITS-1:0]    popped_rank,
  output logic [CNT_W-1:0]        occupancy,
  output logic [PAYLOAD_BITS-1:0] front_payload,
  output logic [RANK_BITS-1:0]    front_rank,
  output logic                    is_empty
);

  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(CAPACITY);

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;

  logic                    in_fire;
  logic                    is_full;
  logic                    is_void;
  spq_ctl_t                ctl;

  logic                    keep_bit  [CAPACITY];
  logic [RANK_BITS-1:0]    cell_rank [CAPACITY];
  logic [PAYLOAD_BITS-1:0] cell_data [CAPACITY];

  spq_status_t             res_status;
  logic [PAYLOAD_BITS-1:0] res_pop_data;
  logic [RANK_BITS-1:0]    res_pop_rank;
  logic [PAYLOAD_BITS-1:0] res_front_data;
  logic [RANK_BITS-1:0]    res_front_rank;

  spq_status_t             status_q;

  assign in_stall = out_valid && out_stall;
  assign in_fire  = in_valid && !in_stall;
  assign is_full  = (count == FULL_CNT);
  assign is_void  = (count == '0);

  assign ctl.push = in_fire && (operation == OP_PUSH) && !is_full;
  assign ctl.pop  = in_fire && (operation == OP_POP) && !is_void;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                    lk;
    logic [RANK_BITS-1:0]    lr;
    logic [PAYLOAD_BITS-1:0] lp;
    logic [RANK_BITS-1:0]    rr;
    logic [PAYLOAD_BITS-1:0] rp;

    if (i == 0) begin : g_head
      // Sentinel: nothing ahead of the head ever moves.
      assign lk = 1'b1;
      assign lr = rank;
      assign lp = payload;
    end else begin : g_body
      assign lk = keep_bit[i-1];
      assign lr = cell_rank[i-1];
      assign lp = cell_data[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign rr = cell_rank[i];
      assign rp = cell_data[i];
    end else begin : g_mid
      assign rr = cell_rank[i+1];
      assign rp = cell_data[i+1];
    end

    spq_cell #(
      .PAYLOAD_BITS (PAYLOAD_BITS),
      .RANK_BITS    (RANK_BITS)
    ) u_cell (
      .clk           (clk),
      .ctl           (ctl),
      .new_rank      (rank),
      .new_payload   (payload),
      .occupied      (CNT_W'(i) < count),
      .left_keep     (lk),
      .left_rank     (lr),
      .left_payload  (lp),
      .right_rank    (rr),
      .right_payload (rp),
      .keep          (keep_bit[i]),
      .slot_rank     (cell_rank[i]),
      .slot_payload  (cell_data[i])
    );
  end

  // Result as seen after the operation, from the current row.
  always_comb begin
    res_status     = ST_OK;
    res_pop_data   = '0;
    res_pop_rank   = '0;
    count_next     = count;
    res_front_data = is_void ? '0 : cell_data[0];
    res_front_rank = is_void ? '0 : cell_rank[0];
    if (operation == OP_PUSH) begin
      if (is_full) begin
        res_status = ST_FULL;
      end else begin
        count_next = count + 1'b1;
        if (!keep_bit[0]) begin
          res_front_data = payload;
          res_front_rank = rank;
        end
      end
    end else begin
      if (is_void) begin
        res_status = ST_EMPTY;
      end else begin
        count_next   = count - 1'b1;
        res_pop_data = cell_data[0];
        res_pop_rank = cell_rank[0];
        if (count == CNT_W'(1)) begin
          res_front_data = '0;
          res_front_rank = '0;
        end else begin
          res_front_data = cell_data[1];
          res_front_rank = cell_rank[1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (in_fire) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      status_q       <= res_status;
      popped_payload <= res_pop_data;
      popped_rank    <= res_pop_rank;
      occupancy      <= count_next;
      front_payload  <= res_front_data;
      front_rank     <= res_front_rank;
      is_empty       <= (count_next == '0);
    end
  end

  assign status = status_q;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_CNT)
    else $error("fill count beyond capacity");

  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (is_empty == (occupancy == '0)))
    else $error("empty flag disagrees with occupancy");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status_q == ST_FULL) |-> (occupancy == FULL_CNT))
    else $error("full status with free slots");

  a_push_count: assert property (@(posedge clk) disable iff (rst)
    ctl.push |=> (count == $past(count) + 1'b1))
    else $error("push did not advance fill count");

  a_pop_head: assert property (@(posedge clk) disable iff (rst)
    (ctl.pop && count > CNT_W'(1)) |=> (cell_rank[0] <= $past(cell_rank[0])))
    else $error("pop raised the head rank");

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// Testbench for the stable priority queue: push/pop traffic checked against a sorted-queue model.
module testbench;
  import spq_pkg::*;

  localparam int CAP          = 16;
  localparam int PW           = 32;
  localparam int RW           = 8;
  localparam int CW           = $clog2(CAP + 1);
  localparam int RANDOM_ITEMS = 1850;
  localparam int MAX_CYCLES   = 400000;
  localparam int DRAIN_CYCLES = 20;

  typedef struct {
    spq_status_t   status;
    logic [PW-1:0] popped_payload;
    logic [RW-1:0] popped_rank;
    logic [CW-1:0] occupancy;
    logic [PW-1:0] front_payload;
    logic [RW-1:0] front_rank;
    logic          is_empty;
  } spq_result_t;

  // Sorted-queue model plus the list of results still owed by the block.
  class queue_scoreboard;
    logic [RW-1:0] slot_rk   [CAP];
    logic [PW-1:0] slot_data [CAP];
    int            fill;
    spq_result_t   owed [$];
    int            errors;

    function new();
      fill   = 0;
      errors = 0;
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    function void note_input(spq_op_t op, logic [PW-1:0] data, logic [RW-1:0] rk);
      spq_result_t r;
      int pos;
      r.status         = ST_OK;
      r.popped_payload = '0;
      r.popped_rank    = '0;
      if (op == OP_PUSH) begin
        if (fill >= CAP) begin
          r.status = ST_FULL;
        end else begin
          // new entry goes behind every entry of equal or higher rank
          pos = 0;
          while (pos < fill && slot_rk[pos] >= rk) pos++;
          for (int k = fill; k > pos; k--) begin
            slot_rk[k]   = slot_rk[k-1];
            slot_data[k] = slot_data[k-1];
          end
          slot_rk[pos]   = rk;
          slot_data[pos] = data;
          fill++;
        end
      end else begin
        if (fill == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.popped_payload = slot_data[0];
          r.popped_rank    = slot_rk[0];
          for (int k = 1; k < fill; k++) begin
            slot_rk[k-1]   = slot_rk[k];
            slot_data[k-1] = slot_data[k];
          end
          fill--;
        end
      end
      r.occupancy     = CW'(fill);
      r.front_payload = (fill != 0) ? slot_data[0] : '0;
      r.front_rank    = (fill != 0) ? slot_rk[0] : '0;
      r.is_empty      = (fill == 0);
      owed.push_back(r);
    endfunction

    task field_check(string name, logic [63:0] got, logic [63:0] want);
      if (got !== want)
        report($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
    endtask

    task check_result(logic [1:0] st, logic [PW-1:0] pp, logic [RW-1:0] pr,
                      logic [CW-1:0] occ, logic [PW-1:0] fp, logic [RW-1:0] fr,
                      logic emp);
      spq_result_t e;
      if (owed.size() == 0) begin
        report($sformatf("result with no pending transaction (status %0d)", st));
        return;
      end
      e = owed.pop_front();
      field_check("status", 64'(st), 64'(e.status));
      field_check("popped_payload", 64'(pp), 64'(e.popped_payload));
      field_check("popped_rank", 64'(pr), 64'(e.popped_rank));
      field_check("occupancy", 64'(occ), 64'(e.occupancy));
      field_check("front_payload", 64'(fp), 64'(e.front_payload));
      field_check("front_rank", 64'(fr), 64'(e.front_rank));
      field_check("is_empty", 64'(emp), 64'(e.is_empty));
    endtask
  endclass

  logic          clk = 1'b0;
  logic          rst;
  logic          in_valid;
  logic          in_stall;
  logic          operation;
  logic [PW-1:0] payload;
  logic [RW-1:0] rank;
  logic          out_valid;
  logic          out_stall;
  logic [1:0]    status;
  logic [PW-1:0] popped_payload;
  logic [RW-1:0] popped_rank;
  logic [CW-1:0] occupancy;
  logic [PW-1:0] front_payload;
  logic [RW-1:0] front_rank;
  logic          is_empty;

  queue_scoreboard sb;
  int cycles     = 0;
  int burst_left = 0;
  int stall_mode = 0;
  int stall_left = 0;

  stable_priority_queue #(
    .CAPACITY    (CAP),
    .PAYLOAD_BITS(PW),
    .RANK_BITS   (RW)
  ) dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .operation     (operation),
    .payload       (payload),
    .rank          (rank),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .popped_payload(popped_payload),
    .popped_rank   (popped_rank),
    .occupancy     (occupancy),
    .front_payload (front_payload),
    .front_rank    (front_rank),
    .is_empty      (is_empty)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > MAX_CYCLES) begin
      $display("Verification failed");
      $finish;
    end
  end

  // sample both channels at the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall)
        sb.note_input(spq_op_t'(operation), payload, rank);
      if (out_valid && !out_stall)
        sb.check_result(status, popped_payload, popped_rank, occupancy,
                        front_payload, front_rank, is_empty);
    end
  end

  // receiver backpressure: switches between a few stall patterns
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(32, 256);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      0: out_stall = 1'b0;
      1: out_stall = ($urandom_range(0, 3) == 0);
      2: out_stall = ($urandom_range(0, 3) != 0);
      default: out_stall = ((cycles % 5) < 2);
    endcase
  end

  // called at a falling edge; returns at a falling edge after the transaction
  task automatic send_item(spq_op_t op, logic [PW-1:0] data, logic [RW-1:0] rk);
    int gap;
    in_valid  = 1'b1;
    operation = op;
    payload   = data;
    rank      = rk;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 30);
      gap = $urandom_range(0, 8);
      if (gap > 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    while (sb.owed.size() != 0) @(negedge clk);
  endtask

  initial begin
    int sent;
    int kind;
    int len;
    int rank_style;
    spq_op_t op;
    logic [RW-1:0] rk;

    sb        = new();
    rst       = 1'b1;
    in_valid  = 1'b0;
    operation = OP_PUSH;
    payload   = '0;
    rank      = '0;
    out_stall = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    // directed: empty pop, extreme fields, ties, full push, refill
    send_item(OP_POP, '1, '1);
    send_item(OP_PUSH, '0, '0);
    send_item(OP_PUSH, '1, '1);
    for (int k = 0; k < CAP - 2; k++)
      send_item(OP_PUSH, 32'h100 + k,
                (k % 3 == 0) ? 8'd128 : (k % 3 == 1) ? 8'd0 : 8'hff);
    send_item(OP_PUSH, 32'hdead_beef, 8'hff);
    send_item(OP_POP, '0, '0);
    send_item(OP_PUSH, 32'h5a5a_a5a5, 8'hff);
    send_item(OP_PUSH, 32'ha5a5_5a5a, 8'h80);
    repeat (4) send_item(OP_POP, $urandom, RW'($urandom));
    wait_drained();

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      kind       = $urandom_range(0, 4);
      len        = $urandom_range(30, 120);
      rank_style = $urandom_range(0, 2);
      for (int i = 0; i < len; i++) begin
        case (kind)
          0: op = ($urandom_range(0, 1) == 0) ? OP_PUSH : OP_POP;
          1: op = ($urandom_range(0, 99) < 85) ? OP_PUSH : OP_POP;
          2: op = ($urandom_range(0, 99) < 15) ? OP_PUSH : OP_POP;
          3: op = (i < len / 2) ? OP_PUSH : OP_POP;  // fill then drain
          default: op = ($urandom_range(0, 99) < 35) ? OP_PUSH : OP_POP;
        endcase
        case (rank_style)
          0: rk = RW'($urandom);
          1: rk = RW'($urandom_range(0, 3));  // heavy ties
          default: rk = ($urandom_range(0, 1) == 0) ? RW'($urandom_range(0, 1))
                                                    : RW'($urandom_range(254, 255));
        endcase
        send_item(op, $urandom, rk);
        sent++;
      end
      if ($urandom_range(0, 3) == 0) wait_drained();
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.owed.size() != 0)
      sb.report($sformatf("%0d results never arrived", sb.owed.size()));
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== stable_priority_queue.f =====
hw/rtl/spq_pkg.sv
hw/rtl/spq_cell.sv
hw/rtl/stable_priority_queue.sv
bench/testbench.sv
